/* hdl/usd_pkg.sv */
package usd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned USED_W = 3;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned WIN_D  = 4;

  localparam logic [CP_W-1:0] ERR_CP_RESET = 21'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;

  localparam logic [BYTE_W-1:0] MASK_1 = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] TRAIL_LO = 8'h80;
  localparam logic [BYTE_W-1:0] TRAIL_HI = 8'hBF;

  // controller to datapath
  typedef struct packed {
    logic load;  // take the input byte into the window
    logic emit;  // register a result and drop its bytes
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wait_more;  // window gives no result now
    logic last;       // result at the front ends the run for this byte
  } sts_t;

  // sequence length from the lead byte, zero for a bad lead
  function automatic logic [USED_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [USED_W-1:0] n;
    n = 3'd0;
    if ((b & MASK_1) == 8'h00) n = 3'd1;
    else if ((b & MASK_2) == LEAD_2) n = 3'd2;
    else if ((b & MASK_3) == LEAD_3) n = 3'd3;
    else if ((b & MASK_4) == LEAD_4) n = 3'd4;
    return n;
  endfunction

  function automatic logic is_trail(input logic [BYTE_W-1:0] b);
    return (b >= TRAIL_LO) && (b <= TRAIL_HI);
  endfunction

endpackage

/* hdl/usd_ctrl.sv */
module usd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  usd_pkg::sts_t sts,
  output usd_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.wait_more) begin
          in_ready  = 1'b1;
          cmd.load  = in_valid;
          state_nxt = in_valid ? S_SCAN : S_IDLE;
        end else if (slot_free) begin
          cmd.emit = 1'b1;
          // last result of the run frees the window for the next byte
          if (sts.last) begin
            in_ready  = 1'b1;
            cmd.load  = in_valid;
            state_nxt = in_valid ? S_SCAN : S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/usd_datapath.sv */
module usd_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [usd_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_end_of_data,
  input  logic                          cfg_wr_en,
  input  logic [usd_pkg::CP_W-1:0]      cfg_wr_data,
  input  usd_pkg::cmd_t                 cmd,
  output usd_pkg::sts_t                 sts,
  output logic [usd_pkg::CP_W-1:0]      out_codepoint,
  output logic [usd_pkg::USED_W-1:0]    out_bytes_used,
  output logic                          out_is_error,
  output logic                          out_last_of_run
);

  logic [usd_pkg::BYTE_W-1:0] window_r [usd_pkg::WIN_D];
  logic [usd_pkg::BYTE_W-1:0] window_nxt [usd_pkg::WIN_D];
  logic [usd_pkg::BYTE_W-1:0] shifted [usd_pkg::WIN_D];
  logic [usd_pkg::BYTE_W-1:0] base [usd_pkg::WIN_D];
  logic [usd_pkg::CNT_W-1:0]  count_r, count_nxt, base_cnt;
  logic                       eod_r;
  logic [usd_pkg::CP_W-1:0]   err_cp_r;

  logic [usd_pkg::CP_W-1:0]   cp_r;
  logic [usd_pkg::USED_W-1:0] used_r;
  logic                       err_r;
  logic                       last_r;

  logic [usd_pkg::USED_W-1:0] need, n_drop, need_next;
  logic [usd_pkg::CNT_W-1:0]  remain;
  logic [usd_pkg::CP_W-1:0]   cp;
  logic                       bad_lead, short_seq, trail_ok, surrogate, fail;

  // evaluate the sequence at the front of the window
  always_comb begin
    need      = usd_pkg::lead_len(window_r[0]);
    bad_lead  = (need == 3'd0);
    short_seq = (count_r < need);
    case (need)
      3'd1:    cp = {14'd0, window_r[0][6:0]};
      3'd2:    cp = {10'd0, window_r[0][4:0], window_r[1][5:0]};
      3'd3:    cp = {5'd0, window_r[0][3:0], window_r[1][5:0], window_r[2][5:0]};
      default: cp = {window_r[0][2:0], window_r[1][5:0], window_r[2][5:0],
                     window_r[3][5:0]};
    endcase
    trail_ok = ((need < 3'd2) || usd_pkg::is_trail(window_r[1])) &&
               ((need < 3'd3) || usd_pkg::is_trail(window_r[2])) &&
               ((need < 3'd4) || usd_pkg::is_trail(window_r[3]));
    surrogate = (cp >= usd_pkg::SURR_LO) && (cp <= usd_pkg::SURR_HI);
    fail      = bad_lead || short_seq || !trail_ok || surrogate;
    n_drop    = fail ? 3'd1 : need;
    remain    = count_r - n_drop;
    need_next = usd_pkg::lead_len(window_r[n_drop[1:0]]);

    sts.wait_more = (count_r == 3'd0) || (!bad_lead && short_seq && !eod_r);
    // run ends when the window empties or the next sequence must wait for bytes
    sts.last = (remain == 3'd0) ||
               ((need_next != 3'd0) && (remain < need_next) && !eod_r);
  end

  always_comb begin
    for (int i = 0; i < usd_pkg::WIN_D; i++) begin
      shifted[i] = window_r[i];
    end
    case (n_drop)
      3'd1: begin
        shifted[0] = window_r[1];
        shifted[1] = window_r[2];
        shifted[2] = window_r[3];
      end
      3'd2: begin
        shifted[0] = window_r[2];
        shifted[1] = window_r[3];
      end
      3'd3: shifted[0] = window_r[3];
      default: ;
    endcase

    base_cnt = cmd.emit ? remain : count_r;
    for (int i = 0; i < usd_pkg::WIN_D; i++) begin
      base[i]       = cmd.emit ? shifted[i] : window_r[i];
      window_nxt[i] = base[i];
    end
    count_nxt = base_cnt;
    if (cmd.load) begin
      window_nxt[base_cnt[1:0]] = in_data_byte;
      count_nxt = base_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      err_cp_r <= usd_pkg::ERR_CP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) err_cp_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < usd_pkg::WIN_D; i++) begin
      window_r[i] <= window_nxt[i];
    end
    if (cmd.load) eod_r <= in_end_of_data;
    if (cmd.emit) begin
      cp_r   <= fail ? err_cp_r : cp;
      used_r <= n_drop;
      err_r  <= fail;
      last_r <= sts.last;
    end
  end

  assign out_codepoint   = cp_r;
  assign out_bytes_used  = used_r;
  assign out_is_error    = err_r;
  assign out_last_of_run = last_r;

endmodule

/* hdl/utf8_stream_decoder.sv */
// channel  direction  ports                                          transaction
// in       input      in_valid/in_ready, in_data_byte, in_end_of_data  one raw byte
// out      output     out_valid/out_ready, out_codepoint, out_bytes_used,
//                     out_is_error, out_last_of_run                   one result
// cfg      input      cfg_wr_en, cfg_wr_data                          error codepoint write
//
// a byte is taken every cycle while each byte yields at most one result and out is free
// a byte that yields k results keeps in_ready low until its last result; one shared
// evaluation unit over the window front produces one result per cycle while out is free
// after an idle spell a byte is loaded into the window, then its first result registered
// synchronous active-low reset empties the window and restores the error codepoint 0xFFFD
// a stall on out holds both the result register and the scan
module utf8_stream_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [usd_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_end_of_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [usd_pkg::CP_W-1:0]    out_codepoint,
  output logic [usd_pkg::USED_W-1:0]  out_bytes_used,
  output logic                        out_is_error,
  output logic                        out_last_of_run,
  input  logic                        cfg_wr_en,
  input  logic [usd_pkg::CP_W-1:0]    cfg_wr_data
);

  usd_pkg::cmd_t cmd;
  usd_pkg::sts_t sts;

  usd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  usd_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .in_end_of_data  (in_end_of_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_codepoint   (out_codepoint),
    .out_bytes_used  (out_bytes_used),
    .out_is_error    (out_is_error),
    .out_last_of_run (out_last_of_run)
  );

endmodule
